// ===== design/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types and constants of the rms power normalizer
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SUM_W  = 39;
  localparam int unsigned SQ_W   = 31;
  localparam int unsigned PAIR_W = 2 * WORD_W;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_COMPLEX_PAIRS   = 2'd0;
  localparam logic [1:0] CFG_NORMALIZE_POWER = 2'd1;
  localparam logic [1:0] CFG_SKIP_WORDS      = 2'd2;

  typedef enum logic {
    CMD_EMIT,
    CMD_FLUSH
  } rpn_cmd_kind_e;

  typedef struct packed {
    rpn_cmd_kind_e             kind;
    logic signed [WORD_W-1:0]  re;
    logic signed [WORD_W-1:0]  im;
    logic                      last;
    logic [SUM_W-1:0]          sum;
    logic [CNT_W-1:0]          count;
  } rpn_cmd_t;

  typedef struct packed {
    logic              complex_pairs;
    logic              normalize_power;
    logic [WORD_W-1:0] skip_words;
  } rpn_cfg_t;

endpackage

`default_nettype wire

// ===== design/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/rpn_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rpn_cmd_fifo
// two entry command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_cmd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rpn_pkg::rpn_cmd_t push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  output rpn_pkg::rpn_cmd_t      pop_data_o,
  input  wire logic              pop_i
);
  import rpn_pkg::*;

  rpn_cmd_t   ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rpn_front.sv =====
// ----------------------------------------------------------------------------
// rpn_front
// takes raw words, skips and pairs them, stores samples and sums their power or passes samples on
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_front #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire rpn_pkg::rpn_cfg_t                                   cfg_i,
  input  wire logic                                                in_valid_i,
  output logic                                                     in_stall_o,
  input  wire logic signed [rpn_pkg::WORD_W-1:0]                   raw_word_i,
  input  wire logic                                                block_end_i,
  output logic                                                     push_o,
  output rpn_pkg::rpn_cmd_t                                        cmd_o,
  input  wire logic                                                full_i,
  input  wire logic                                                flush_done_i,
  output logic                                                     ram_we_o,
  output logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] ram_waddr_o,
  output logic [rpn_pkg::PAIR_W-1:0]                               ram_wdata_o
);
  import rpn_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic                     half_q, half_d;
  logic signed [WORD_W-1:0] held_q, held_d;
  logic [WORD_W-1:0]        skipped_q, skipped_d;
  logic [CNT_W-1:0]         count_q, cnt_after;
  logic [SUM_W-1:0]         sum_q, sum_n;
  logic [SQ_W-1:0]          sq_re_q, sq_im_q;
  logic                     acc_q;
  logic                     go_flush_q, flush_pend_q;
  logic                     accept, have, store, emit, end_acc, flush_push;
  logic signed [WORD_W-1:0] s_re, s_im;
  logic signed [PAIR_W-1:0] p_re, p_im;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = full_i || go_flush_q || flush_pend_q;

  always_comb begin
    have      = 1'b0;
    s_re      = '0;
    s_im      = '0;
    half_d    = half_q;
    held_d    = held_q;
    skipped_d = skipped_q;
    if (half_q) begin
      s_re   = held_q;
      s_im   = raw_word_i;
      have   = 1'b1;
      half_d = 1'b0;
    end else if (skipped_q < cfg_i.skip_words) begin
      skipped_d = skipped_q + 1'b1;
    end else if (cfg_i.complex_pairs) begin
      held_d = raw_word_i;
      half_d = 1'b1;
    end else begin
      s_re = raw_word_i;
      have = 1'b1;
    end
    // block ends after a real part: pad the pair with zero
    if (block_end_i && half_d) begin
      s_re   = held_d;
      s_im   = '0;
      have   = 1'b1;
      half_d = 1'b0;
    end
  end

  assign store      = accept && have && cfg_i.normalize_power
                      && (count_q < CNT_W'(MAX_SAMPLES));
  assign emit       = accept && have && !cfg_i.normalize_power;
  assign end_acc    = accept && block_end_i;
  assign cnt_after  = count_q + {{(CNT_W-1){1'b0}}, store};
  assign flush_push = go_flush_q && !full_i;
  assign push_o     = emit || flush_push;

  assign p_re  = s_re * s_re;
  assign p_im  = s_im * s_im;
  assign sum_n = acc_q ? (sum_q + SUM_W'(sq_re_q) + SUM_W'(sq_im_q)) : sum_q;

  always_comb begin
    cmd_o = '0;
    if (go_flush_q) begin
      cmd_o.kind  = CMD_FLUSH;
      cmd_o.sum   = sum_n;
      cmd_o.count = count_q;
    end else begin
      cmd_o.kind = CMD_EMIT;
      cmd_o.re   = s_re;
      cmd_o.im   = s_im;
      cmd_o.last = block_end_i;
    end
  end

  assign ram_we_o    = store;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = {s_im, s_re};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q       <= 1'b0;
      held_q       <= '0;
      skipped_q    <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      acc_q        <= 1'b0;
      go_flush_q   <= 1'b0;
      flush_pend_q <= 1'b0;
    end else begin
      acc_q <= store;
      if (accept) begin
        if (block_end_i) begin
          half_q    <= 1'b0;
          held_q    <= '0;
          skipped_q <= '0;
        end else begin
          half_q    <= half_d;
          held_q    <= held_d;
          skipped_q <= skipped_d;
        end
      end
      if (flush_push) begin
        sum_q        <= '0;
        count_q      <= '0;
        go_flush_q   <= 1'b0;
        flush_pend_q <= 1'b1;
      end else if (end_acc && !(cfg_i.normalize_power && cnt_after != '0)) begin
        // block closes with nothing kept to flush
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_n;
        count_q <= cnt_after;
        if (end_acc) begin
          go_flush_q <= 1'b1;
        end
      end
      if (flush_done_i) begin
        flush_pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_re_q <= p_re[SQ_W-1:0];
    sq_im_q <= p_im[SQ_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/rpn_back.sv =====
// ----------------------------------------------------------------------------
// rpn_back
// executes queued commands: passes samples through or flushes the stored block
// scaled by the inverse of its rms, with one shared divider and square root unit
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_back #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire logic                                                cmd_valid_i,
  input  wire rpn_pkg::rpn_cmd_t                                   cmd_i,
  output logic                                                     pop_o,
  output logic                                                     ram_re_o,
  output logic [((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1)-1:0] ram_raddr_o,
  input  wire logic [rpn_pkg::PAIR_W-1:0]                          ram_rdata_i,
  output logic                                                     out_valid_o,
  input  wire logic                                                out_stall_i,
  output logic signed [rpn_pkg::WORD_W-1:0]                        out_real_o,
  output logic signed [rpn_pkg::WORD_W-1:0]                        out_imag_o,
  output logic                                                     out_last_o,
  output logic                                                     zero_power_o,
  output logic                                                     flush_done_o,
  output logic                                                     busy_o
);
  import rpn_pkg::*;

  localparam int unsigned AW       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned QUO_W    = 33;
  localparam int unsigned RAD_W    = 34;
  localparam int unsigned ROOT_W   = 17;
  localparam int unsigned SREM_W   = 21;
  localparam int unsigned PROD_W   = 37;
  localparam logic [5:0]  DIV_LAST = 6'd32;
  localparam logic [5:0]  SQ_LAST  = 6'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CAPT,
    ST_SQR,
    ST_SCALE,
    ST_DIV,
    ST_SQRT,
    ST_ROUND,
    ST_OUT
  } state_e;

  state_e                   state_q;
  logic [SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]         cnt_q, idx_q;
  logic [PAIR_W-1:0]        smp_q;
  logic                     part_q, zero_q;
  logic [PAIR_W-1:0]        sq_q;
  logic [SUM_W-1:0]         rem_q;
  logic [QUO_W-1:0]         dvd_q, quo_q;
  logic [RAD_W-1:0]         rad_q;
  logic [SREM_W-1:0]        srem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [5:0]               step_q;
  logic signed [WORD_W-1:0] res_re_q, res_im_q;

  logic                     out_free, is_last, out_load, done_load;
  logic signed [WORD_W-1:0] cur;
  logic [WORD_W-1:0]        mag;
  logic [SUM_W-1:0]         prod;
  logic [SUM_W:0]           remsh;
  logic                     dgo;
  logic [QUO_W-1:0]         quo_n;
  logic [SREM_W-1:0]        srem_sh, trial;
  logic [ROOT_W:0]          rnd_sum;
  logic [ROOT_W-1:0]        rnd;
  logic [WORD_W-1:0]        res;

  assign out_free    = !out_valid_o || !out_stall_i;
  assign pop_o       = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign ram_re_o    = (state_q == ST_READ);
  assign ram_raddr_o = idx_q[AW-1:0];
  assign busy_o      = (state_q != ST_IDLE);
  assign is_last     = ((idx_q + 1'b1) == cnt_q);

  // output register is loaded by a pass-through command or a flushed sample
  assign out_load  = (pop_o && (cmd_i.kind == CMD_EMIT)) || ((state_q == ST_OUT) && out_free);
  assign done_load = (state_q == ST_OUT) && out_free && is_last;

  assign cur  = part_q ? $signed(smp_q[PAIR_W-1:WORD_W]) : $signed(smp_q[WORD_W-1:0]);
  assign mag  = cur[WORD_W-1] ? WORD_W'(-cur) : WORD_W'(cur);
  assign prod = sq_q * cnt_q;

  // one restoring quotient bit per cycle
  assign remsh = {rem_q, dvd_q[QUO_W-1]};
  assign dgo   = (remsh >= {1'b0, sum_q});
  assign quo_n = {quo_q[QUO_W-2:0], dgo};

  // one root bit per cycle
  assign srem_sh = {srem_q[SREM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial   = {2'b00, root_q, 2'b01};

  assign rnd_sum = {1'b0, root_q} + 1'b1;
  assign rnd     = rnd_sum[ROOT_W:1];

  always_comb begin
    if (!cur[WORD_W-1]) begin
      res = (rnd > ROOT_W'(32767)) ? 16'h7fff : rnd[WORD_W-1:0];
    end else if (rnd > ROOT_W'(32768)) begin
      res = 16'h8000;
    end else begin
      res = WORD_W'(~rnd + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_o  <= 1'b0;
      flush_done_o <= 1'b0;
    end else begin
      flush_done_o <= done_load;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (cmd_i.kind == CMD_EMIT) begin
              out_real_o   <= cmd_i.re;
              out_imag_o   <= cmd_i.im;
              out_last_o   <= cmd_i.last;
              zero_power_o <= 1'b0;
            end else begin
              sum_q   <= cmd_i.sum;
              cnt_q   <= cmd_i.count;
              idx_q   <= '0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_CAPT;
        end
        ST_CAPT: begin
          smp_q  <= ram_rdata_i;
          part_q <= 1'b0;
          zero_q <= (sum_q == '0);
          if (sum_q == '0) begin
            res_re_q <= '0;
            res_im_q <= '0;
            state_q  <= ST_OUT;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          sq_q    <= PAIR_W'(mag) * PAIR_W'(mag);
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          // dividend is prod << 26; its top bits start the remainder
          rem_q   <= SUM_W'(prod[PROD_W-1:7]);
          dvd_q   <= {prod[6:0], 26'd0};
          quo_q   <= '0;
          step_q  <= DIV_LAST;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= dgo ? SUM_W'(remsh - {1'b0, sum_q}) : remsh[SUM_W-1:0];
          dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
          quo_q  <= quo_n;
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            rad_q   <= {1'b0, quo_n};
            srem_q  <= '0;
            root_q  <= '0;
            step_q  <= SQ_LAST;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (srem_sh >= trial) begin
            srem_q <= srem_sh - trial;
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            srem_q <= srem_sh;
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (!part_q) begin
            res_re_q <= res;
            part_q   <= 1'b1;
            state_q  <= ST_SQR;
          end else begin
            res_im_q <= res;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_real_o   <= res_re_q;
            out_imag_o   <= res_im_q;
            out_last_o   <= is_last;
            zero_power_o <= zero_q;
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rms_power_normalizer.sv =====
// ----------------------------------------------------------------------------
// rms_power_normalizer
// block rms normalization of real or i/q sample streams
// ----------------------------------------------------------------------------
// Raw words are taken one per cycle while a block loads and the input is not
// stalled; the front skips the leading words, pairs i/q parts, stores up to
// MAX_SAMPLES samples and sums their power. A pass-through sample is queued as
// its word is taken and then registered into the output by the back; it waits
// longer while the output stalls. After the last word of a normalized block,
// input stalls while the block is flushed: each sample passes the shared
// one-bit-per-cycle divider (33 steps) and square root unit (17 steps) that
// handle the real and imaginary parts in turn. A zero-power block skips them
// and passes only the read, capture and output states per sample.
`default_nettype none

module rms_power_normalizer #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [rpn_pkg::WORD_W-1:0]  raw_word_i,
  input  wire logic                               block_end_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [rpn_pkg::WORD_W-1:0]       out_real_o,
  output logic signed [rpn_pkg::WORD_W-1:0]       out_imag_o,
  output logic                                    out_last_o,
  output logic                                    zero_power_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [1:0]                         cfg_index_i,
  input  wire logic [rpn_pkg::WORD_W-1:0]         cfg_data_i
);
  import rpn_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  rpn_cfg_t          cfg_q;
  rpn_cmd_t          push_cmd, pop_cmd;
  logic              push, pop, full, cmd_valid, flush_done, busy;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [PAIR_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.complex_pairs   <= 1'b1;
      cfg_q.normalize_power <= 1'b1;
      cfg_q.skip_words      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COMPLEX_PAIRS:   cfg_q.complex_pairs   <= cfg_data_i[0];
        CFG_NORMALIZE_POWER: cfg_q.normalize_power <= cfg_data_i[0];
        CFG_SKIP_WORDS:      cfg_q.skip_words      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rpn_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_word_i  (raw_word_i),
    .block_end_i (block_end_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .full_i      (full),
    .flush_done_i(flush_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  rpn_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (full),
    .valid_o    (cmd_valid),
    .pop_data_o (pop_cmd),
    .pop_i      (pop)
  );

  rpn_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rpn_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_real_o  (out_real_o),
    .out_imag_o  (out_imag_o),
    .out_last_o  (out_last_o),
    .zero_power_o(zero_power_o),
    .flush_done_o(flush_done),
    .busy_o      (busy)
  );

  // the store is never written while a flush reads it
  a_no_write_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !busy)
    else $error("sample store written during flush");

  // a zero-power result carries zero parts
  a_zero_parts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_power_o) |-> (out_real_o == '0 && out_imag_o == '0))
    else $error("zero power result with nonzero parts");

  // no word is taken while the back flushes a block
  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("word accepted during flush");

  // a flush only ends on a delivered last sample
  a_done_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_done |-> (out_valid_o && out_last_o))
    else $error("flush finished without last sample");

endmodule

`default_nettype wire
